[sv/fan_duty_slew_and_alarm_defines.svh]
// assertion macros for the fan duty slew and alarm block
// used by the port checker; depends on nothing else
`ifndef FAN_DUTY_SLEW_AND_ALARM_DEFINES_SVH
`define FAN_DUTY_SLEW_AND_ALARM_DEFINES_SVH

// property checked while out of reset
`define FDSA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked on every edge, reset included
`define FDSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/fdsa_pkg.sv]
// types, constants and field layout for the fan duty slew and alarm block
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package fdsa_pkg;

    localparam int FAN_COUNT = 8;
    localparam int FAN_IDX_W = (FAN_COUNT > 1) ? $clog2(FAN_COUNT) : 1;

    localparam int FAN_W    = 3;
    localparam int DUTY_W   = 7;
    localparam int RPM_W    = 16;
    localparam int SRC_W    = 2;
    localparam int TEMP_W   = 16;
    localparam int ALARM_W  = 2;
    localparam int EVENT_W  = 2;
    localparam int STALL_W  = 2;
    localparam int MODE_W   = 2;
    localparam int LIMIT_W  = 8;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    localparam logic [DUTY_W-1:0]  FULL_DUTY   = 7'd100;
    localparam logic [STALL_W-1:0] STALL_LIMIT = 2'd3;

    // alarm kinds
    localparam logic [ALARM_W-1:0] ALARM_NONE     = 2'd0;
    localparam logic [ALARM_W-1:0] ALARM_STALL    = 2'd1;
    localparam logic [ALARM_W-1:0] ALARM_OVERTEMP = 2'd2;

    // alarm events
    localparam logic [EVENT_W-1:0] EVENT_NONE    = 2'd0;
    localparam logic [EVENT_W-1:0] EVENT_RAISED  = 2'd1;
    localparam logic [EVENT_W-1:0] EVENT_CLEARED = 2'd2;

    // failsafe policies
    localparam logic [MODE_W-1:0] FS_HOLD = 2'd0;
    localparam logic [MODE_W-1:0] FS_FULL = 2'd1;
    localparam logic [MODE_W-1:0] FS_SAFE = 2'd2;
    localparam logic [MODE_W-1:0] FS_ALT  = 2'd3;

    // source states
    localparam logic [SRC_W-1:0] SRC_VALID   = 2'd0;
    localparam logic [SRC_W-1:0] SRC_USABLE  = 2'd1;
    localparam logic [SRC_W-1:0] SRC_INVALID = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HYST          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_UP       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_DOWN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAILSAFE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_DUTY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OT_LIMIT      = 3'd5;

    // register reset values
    localparam logic [DUTY_W-1:0]  RST_HYST          = 7'd3;
    localparam logic [DUTY_W-1:0]  RST_RAMP_UP       = 7'd10;
    localparam logic [DUTY_W-1:0]  RST_RAMP_DOWN     = 7'd3;
    localparam logic [MODE_W-1:0]  RST_FAILSAFE      = FS_SAFE;
    localparam logic [DUTY_W-1:0]  RST_FALLBACK_DUTY = 7'd50;
    localparam logic [LIMIT_W-1:0] RST_OT_LIMIT      = 8'd80;

    // result field positions in m_tdata
    localparam int M_DUTY_WR_BIT = 3;
    localparam int M_DUTY_LO     = 4;
    localparam int M_EVENT_LO    = 11;
    localparam int M_KIND_LO     = 13;
    localparam int M_BAD_BIT     = 15;

    typedef struct packed {
        logic [DUTY_W-1:0]  curve_duty;
        logic               curve_found;
        logic [TEMP_W-1:0]  temperature;
        logic [SRC_W-1:0]   source_state;
        logic [RPM_W-1:0]   measured_rpm;
        logic [DUTY_W-1:0]  measured_duty;
        logic               auto_mode;
        logic               fan_enabled;
        logic [FAN_W-1:0]   fan_id;
    } fan_item_t;

    localparam int ITEM_W = $bits(fan_item_t);

    typedef struct packed {
        logic               source_bad_event;
        logic [ALARM_W-1:0] alarm_kind;
        logic [EVENT_W-1:0] alarm_event;
        logic [DUTY_W-1:0]  duty_value;
        logic               duty_write;
        logic [FAN_W-1:0]   out_fan;
    } fan_result_t;

    typedef struct packed {
        logic [DUTY_W-1:0]  hysteresis_band;
        logic [DUTY_W-1:0]  ramp_up_step;
        logic [DUTY_W-1:0]  ramp_down_step;
        logic [MODE_W-1:0]  failsafe_mode;
        logic [DUTY_W-1:0]  fallback_duty;
        logic [LIMIT_W-1:0] overtemp_limit;
    } cfg_t;

    typedef struct packed {
        logic [STALL_W-1:0] stall_ticks;
        logic [DUTY_W-1:0]  last_duty;
        logic [ALARM_W-1:0] last_alarm;
    } fan_state_t;

endpackage

[sv/fdsa_cfg.sv]
// configuration register file of the fan duty slew and alarm block
// depends on fdsa_pkg
`timescale 1ns / 1ps

module fdsa_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic [fdsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fdsa_pkg::CFG_DAT_W-1:0]  cfg_data,
    output fdsa_pkg::cfg_t                  cfg
);

    fdsa_pkg::cfg_t                 cfg_reg;
    fdsa_pkg::cfg_t                 cfg_next;
    logic [fdsa_pkg::DUTY_W-1:0]    v7;
    logic                           v7_ok;

    assign v7    = cfg_data[fdsa_pkg::DUTY_W-1:0];
    assign v7_ok = (v7 <= fdsa_pkg::FULL_DUTY);

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                fdsa_pkg::REG_HYST: begin
                    if (v7_ok) cfg_next.hysteresis_band = v7;
                end
                fdsa_pkg::REG_RAMP_UP: begin
                    if (v7_ok) cfg_next.ramp_up_step = v7;
                end
                fdsa_pkg::REG_RAMP_DOWN: begin
                    if (v7_ok) cfg_next.ramp_down_step = v7;
                end
                fdsa_pkg::REG_FAILSAFE: begin
                    cfg_next.failsafe_mode = cfg_data[fdsa_pkg::MODE_W-1:0];
                end
                fdsa_pkg::REG_FALLBACK_DUTY: begin
                    if (v7_ok) cfg_next.fallback_duty = v7;
                end
                fdsa_pkg::REG_OT_LIMIT: begin
                    cfg_next.overtemp_limit = cfg_data[fdsa_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hysteresis_band <= fdsa_pkg::RST_HYST;
            cfg_reg.ramp_up_step    <= fdsa_pkg::RST_RAMP_UP;
            cfg_reg.ramp_down_step  <= fdsa_pkg::RST_RAMP_DOWN;
            cfg_reg.failsafe_mode   <= fdsa_pkg::RST_FAILSAFE;
            cfg_reg.fallback_duty   <= fdsa_pkg::RST_FALLBACK_DUTY;
            cfg_reg.overtemp_limit  <= fdsa_pkg::RST_OT_LIMIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/fdsa_tick.sv]
// per-tick decision logic: stall count, failsafe, hysteresis, ramp, alarms
// depends on fdsa_pkg
`timescale 1ns / 1ps

module fdsa_tick (
    input  fdsa_pkg::fan_item_t     item,
    input  logic                    in_range,
    input  fdsa_pkg::cfg_t          cfg,
    input  fdsa_pkg::fan_state_t    cur,
    output fdsa_pkg::fan_result_t   result,
    output fdsa_pkg::fan_state_t    nxt,
    output logic                    state_we
);

    logic [fdsa_pkg::DUTY_W-1:0]    tgt;
    logic [fdsa_pkg::DUTY_W-1:0]    held;
    logic [fdsa_pkg::DUTY_W-1:0]    band_diff;
    logic [fdsa_pkg::DUTY_W-1:0]    fin;
    logic [fdsa_pkg::ALARM_W-1:0]   alarm;
    logic signed [fdsa_pkg::TEMP_W-1:0] limit16;
    logic                           hot;

    // limit in whole degrees scaled to 1/16 degree
    assign limit16 = {{(fdsa_pkg::TEMP_W - fdsa_pkg::LIMIT_W - 4){cfg.overtemp_limit[7]}},
                      cfg.overtemp_limit, 4'b0000};
    assign hot = $signed(item.temperature) > limit16;

    // target saturation, hysteresis band, then ramp limit
    always_comb begin
        tgt = (item.curve_duty > fdsa_pkg::FULL_DUTY) ? fdsa_pkg::FULL_DUTY
                                                      : item.curve_duty;
        band_diff = (tgt > cur.last_duty) ? (tgt - cur.last_duty) : (cur.last_duty - tgt);
        held = (band_diff <= cfg.hysteresis_band) ? cur.last_duty : tgt;
        if (held > cur.last_duty) begin
            fin = ((held - cur.last_duty) > cfg.ramp_up_step) ?
                  (cur.last_duty + cfg.ramp_up_step) : held;
        end else if (held < cur.last_duty) begin
            fin = ((cur.last_duty - held) > cfg.ramp_down_step) ?
                  (cur.last_duty - cfg.ramp_down_step) : held;
        end else begin
            fin = cur.last_duty;
        end
    end

    always_comb begin
        nxt      = cur;
        state_we = 1'b0;
        alarm    = fdsa_pkg::ALARM_NONE;
        result.out_fan          = item.fan_id;
        result.duty_write       = 1'b0;
        result.duty_value       = '0;
        result.alarm_event      = fdsa_pkg::EVENT_NONE;
        result.alarm_kind       = in_range ? cur.last_alarm : fdsa_pkg::ALARM_NONE;
        result.source_bad_event = 1'b0;

        if (item.fan_enabled && in_range) begin
            state_we = 1'b1;
            if ((item.measured_duty != '0) && (item.measured_rpm == '0)) begin
                if (cur.stall_ticks < fdsa_pkg::STALL_LIMIT) begin
                    nxt.stall_ticks = cur.stall_ticks + 2'd1;
                end
                if (nxt.stall_ticks >= fdsa_pkg::STALL_LIMIT) begin
                    alarm = fdsa_pkg::ALARM_STALL;
                end
            end else begin
                nxt.stall_ticks = '0;
            end

            if (item.auto_mode) begin
                if (item.source_state[1]) begin
                    // invalid source: failsafe policy
                    result.source_bad_event = 1'b1;
                    case (cfg.failsafe_mode)
                        fdsa_pkg::FS_FULL: begin
                            result.duty_write = 1'b1;
                            result.duty_value = fdsa_pkg::FULL_DUTY;
                        end
                        fdsa_pkg::FS_SAFE: begin
                            result.duty_write = 1'b1;
                            result.duty_value = cfg.fallback_duty;
                        end
                        default: begin
                        end
                    endcase
                end else if (item.curve_found) begin
                    nxt.last_duty     = fin;
                    result.duty_write = 1'b1;
                    result.duty_value = fin;
                    if ((item.source_state == fdsa_pkg::SRC_VALID) && hot) begin
                        alarm = fdsa_pkg::ALARM_OVERTEMP;
                    end
                end
            end

            if ((alarm != fdsa_pkg::ALARM_NONE) && (cur.last_alarm == fdsa_pkg::ALARM_NONE)) begin
                result.alarm_event = fdsa_pkg::EVENT_RAISED;
            end else if ((alarm == fdsa_pkg::ALARM_NONE) &&
                         (cur.last_alarm != fdsa_pkg::ALARM_NONE)) begin
                result.alarm_event = fdsa_pkg::EVENT_CLEARED;
            end
            nxt.last_alarm    = alarm;
            result.alarm_kind = alarm;
        end
    end

endmodule

[sv/fan_duty_slew_and_alarm.sv]
// top level of the fan duty slew and alarm block: stream ports, per-fan state
// depends on fdsa_pkg, fdsa_cfg and fdsa_tick
//
// channel   direction  handshake                 payload
// s_        in         s_tvalid / s_tready       s_tdata, one fan control tick
// m_        out        m_tvalid / m_tready       m_tdata, one result per tick
// cfg_      in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one request per cycle while m_tready is high; a request passes the input register, then the result register
// per-fan state is read, updated and written in the cycle a request moves from
// the input register to the result register, so the next request sees it
// synchronous active-low reset clears config, per-fan state and both valid flags
// a stalled m_ side holds the result; the input register still takes one request
// cfg_ready is always high
`timescale 1ns / 1ps

module fan_duty_slew_and_alarm (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // fan_id, fan_enabled, auto_mode, measured_duty, measured_rpm,
    // source_state, temperature, curve_found, curve duty, zero pad
    input  logic [fdsa_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_fan, duty_write, duty_value, alarm_event, alarm_kind, source_bad_event
    output logic [fdsa_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fdsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fdsa_pkg::CFG_DAT_W-1:0]  cfg_data
);

    fdsa_pkg::cfg_t                     cfg;
    fdsa_pkg::fan_item_t                item_reg;
    logic                               item_valid_reg;
    fdsa_pkg::fan_result_t              result_reg;
    fdsa_pkg::fan_result_t              result_next;
    logic                               result_valid_reg;
    logic                               advance;
    logic                               in_range;
    logic [fdsa_pkg::FAN_IDX_W-1:0]     fan_idx;
    fdsa_pkg::fan_state_t               cur;
    fdsa_pkg::fan_state_t               nxt;
    logic                               state_we;

    logic [fdsa_pkg::STALL_W-1:0]   stall_reg [fdsa_pkg::FAN_COUNT];
    logic [fdsa_pkg::DUTY_W-1:0]    duty_reg  [fdsa_pkg::FAN_COUNT];
    logic [fdsa_pkg::ALARM_W-1:0]   alarm_reg [fdsa_pkg::FAN_COUNT];

    assign cfg_ready = 1'b1;

    fdsa_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign advance  = item_valid_reg && (!result_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_tready) begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= fdsa_pkg::fan_item_t'(s_tdata[fdsa_pkg::ITEM_W-1:0]);
        end
    end

    // per-fan state lookup
    assign in_range = (32'(item_reg.fan_id) < fdsa_pkg::FAN_COUNT);
    assign fan_idx  = fdsa_pkg::FAN_IDX_W'(item_reg.fan_id);

    always_comb begin
        cur.stall_ticks = stall_reg[fan_idx];
        cur.last_duty   = duty_reg[fan_idx];
        cur.last_alarm  = alarm_reg[fan_idx];
    end

    fdsa_tick u_tick (
        .item     (item_reg),
        .in_range (in_range),
        .cfg      (cfg),
        .cur      (cur),
        .result   (result_next),
        .nxt      (nxt),
        .state_we (state_we)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < fdsa_pkg::FAN_COUNT; i++) begin
                stall_reg[i] <= '0;
                duty_reg[i]  <= '0;
                alarm_reg[i] <= fdsa_pkg::ALARM_NONE;
            end
        end else if (advance && state_we) begin
            stall_reg[fan_idx] <= nxt.stall_ticks;
            duty_reg[fan_idx]  <= nxt.last_duty;
            alarm_reg[fan_idx] <= nxt.last_alarm;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            result_valid_reg <= 1'b0;
        end else if (advance) begin
            result_valid_reg <= 1'b1;
        end else if (m_tready) begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = result_valid_reg;
    assign m_tdata  = fdsa_pkg::M_TDATA_W'(result_reg);

endmodule

[sv/fdsa_checker.sv]
// port-level checker for the fan duty slew and alarm block, bound to the top level
// depends on fdsa_pkg and fan_duty_slew_and_alarm_defines.svh
`timescale 1ns / 1ps
`include "fan_duty_slew_and_alarm_defines.svh"

module fdsa_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [fdsa_pkg::M_TDATA_W-1:0]  m_tdata
);

    logic                               duty_wr;
    logic [fdsa_pkg::DUTY_W-1:0]        duty_val;
    logic [fdsa_pkg::EVENT_W-1:0]       event_code;
    logic [fdsa_pkg::ALARM_W-1:0]       kind;
    logic                               bad;

    assign duty_wr    = m_tdata[fdsa_pkg::M_DUTY_WR_BIT];
    assign duty_val   = m_tdata[fdsa_pkg::M_DUTY_LO +: fdsa_pkg::DUTY_W];
    assign event_code = m_tdata[fdsa_pkg::M_EVENT_LO +: fdsa_pkg::EVENT_W];
    assign kind       = m_tdata[fdsa_pkg::M_KIND_LO +: fdsa_pkg::ALARM_W];
    assign bad        = m_tdata[fdsa_pkg::M_BAD_BIT];

    `FDSA_ASSERT(a_result_held, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
    `FDSA_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")
    `FDSA_ASSERT(a_idle_duty_zero, aclk, aresetn, m_tvalid && !duty_wr |-> duty_val == '0, "duty value without duty write")
    `FDSA_ASSERT(a_raise_kind, aclk, aresetn, m_tvalid && (event_code == fdsa_pkg::EVENT_RAISED) |-> kind != fdsa_pkg::ALARM_NONE, "alarm raised with no alarm kind")
    `FDSA_ASSERT(a_bad_not_hot, aclk, aresetn, m_tvalid && bad |-> kind != fdsa_pkg::ALARM_OVERTEMP, "over-temperature on a bad source")

endmodule

bind fan_duty_slew_and_alarm fdsa_checker u_fdsa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/sv/fan_duty_slew_and_alarm_test.sv]
// self-checking bench for fan_duty_slew_and_alarm: directed ticks, then random ticks under
// several register settings, each result checked field by field against a local predictor
// depends on fdsa_pkg and the fan_duty_slew_and_alarm top level
`timescale 1ns / 1ps

module fan_duty_slew_and_alarm_test;

    localparam logic [fdsa_pkg::SRC_W-1:0]     SRC_RESERVED   = 2'd3;
    localparam logic [fdsa_pkg::CFG_IDX_W-1:0] REG_UNUSED_A   = 3'd6;
    localparam logic [fdsa_pkg::CFG_IDX_W-1:0] REG_UNUSED_B   = 3'd7;
    localparam int                             WATCHDOG_LIMIT = 2000;

    class fan_result_board;
        fdsa_pkg::cfg_t        regs;
        fdsa_pkg::fan_state_t  fans [fdsa_pkg::FAN_COUNT];
        fdsa_pkg::fan_result_t expected_results [$];
        int                    errors;

        function new();
            regs.hysteresis_band = fdsa_pkg::RST_HYST;
            regs.ramp_up_step    = fdsa_pkg::RST_RAMP_UP;
            regs.ramp_down_step  = fdsa_pkg::RST_RAMP_DOWN;
            regs.failsafe_mode   = fdsa_pkg::RST_FAILSAFE;
            regs.fallback_duty   = fdsa_pkg::RST_FALLBACK_DUTY;
            regs.overtemp_limit  = fdsa_pkg::RST_OT_LIMIT;
            foreach (fans[i]) fans[i] = '0;
            errors = 0;
        endfunction

        task report_mismatch(input string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        // duty registers drop values above full duty
        function void write_reg(input logic [fdsa_pkg::CFG_IDX_W-1:0] idx,
                                input logic [fdsa_pkg::CFG_DAT_W-1:0] data);
            logic [fdsa_pkg::DUTY_W-1:0] v7;
            logic                        v7_ok;
            v7    = data[fdsa_pkg::DUTY_W-1:0];
            v7_ok = (v7 <= fdsa_pkg::FULL_DUTY);
            case (idx)
                fdsa_pkg::REG_HYST: begin
                    if (v7_ok) regs.hysteresis_band = v7;
                end
                fdsa_pkg::REG_RAMP_UP: begin
                    if (v7_ok) regs.ramp_up_step = v7;
                end
                fdsa_pkg::REG_RAMP_DOWN: begin
                    if (v7_ok) regs.ramp_down_step = v7;
                end
                fdsa_pkg::REG_FAILSAFE:  regs.failsafe_mode = data[fdsa_pkg::MODE_W-1:0];
                fdsa_pkg::REG_FALLBACK_DUTY: begin
                    if (v7_ok) regs.fallback_duty = v7;
                end
                fdsa_pkg::REG_OT_LIMIT:  regs.overtemp_limit = data;
                default: ;
            endcase
        endfunction

        function fdsa_pkg::fan_result_t predict_fan_result(input fdsa_pkg::fan_item_t t);
            fdsa_pkg::fan_result_t        r;
            logic [fdsa_pkg::ALARM_W-1:0] kind;
            int                           f, cur, tgt, diff, fin, lim, temp;
            r = '0;
            r.out_fan = t.fan_id;
            f = t.fan_id;
            kind = fdsa_pkg::ALARM_NONE;
            if (!t.fan_enabled || f >= fdsa_pkg::FAN_COUNT) begin
                r.alarm_kind = (f < fdsa_pkg::FAN_COUNT) ? fans[f].last_alarm
                                                         : fdsa_pkg::ALARM_NONE;
                return r;
            end
            if (t.measured_duty != 0 && t.measured_rpm == 0) begin
                if (fans[f].stall_ticks < fdsa_pkg::STALL_LIMIT)
                    fans[f].stall_ticks = fans[f].stall_ticks + 1'b1;
                if (fans[f].stall_ticks >= fdsa_pkg::STALL_LIMIT) kind = fdsa_pkg::ALARM_STALL;
            end else begin
                fans[f].stall_ticks = '0;
            end
            if (t.auto_mode) begin
                if (t.source_state >= fdsa_pkg::SRC_INVALID) begin
                    r.source_bad_event = 1'b1;
                    if (regs.failsafe_mode == fdsa_pkg::FS_FULL) begin
                        r.duty_write = 1'b1;
                        r.duty_value = fdsa_pkg::FULL_DUTY;
                    end else if (regs.failsafe_mode == fdsa_pkg::FS_SAFE) begin
                        r.duty_write = 1'b1;
                        r.duty_value = regs.fallback_duty;
                    end
                end else if (t.curve_found) begin
                    cur = fans[f].last_duty;
                    tgt = (t.curve_duty > fdsa_pkg::FULL_DUTY) ? fdsa_pkg::FULL_DUTY
                                                               : t.curve_duty;
                    // hysteresis first, then the ramp limits
                    diff = (tgt > cur) ? tgt - cur : cur - tgt;
                    if (diff <= regs.hysteresis_band) tgt = cur;
                    if (tgt > cur)
                        fin = (tgt - cur > regs.ramp_up_step) ? cur + regs.ramp_up_step : tgt;
                    else if (tgt < cur)
                        fin = (cur - tgt > regs.ramp_down_step) ? cur - regs.ramp_down_step
                                                                : tgt;
                    else
                        fin = cur;
                    fans[f].last_duty = fdsa_pkg::DUTY_W'(fin);
                    r.duty_write = 1'b1;
                    r.duty_value = fdsa_pkg::DUTY_W'(fin);
                    lim = $signed(regs.overtemp_limit);
                    temp = $signed(t.temperature);
                    if (t.source_state == fdsa_pkg::SRC_VALID && temp > lim * 16)
                        kind = fdsa_pkg::ALARM_OVERTEMP;
                end
            end
            if (kind != fdsa_pkg::ALARM_NONE && fans[f].last_alarm == fdsa_pkg::ALARM_NONE)
                r.alarm_event = fdsa_pkg::EVENT_RAISED;
            else if (kind == fdsa_pkg::ALARM_NONE && fans[f].last_alarm != fdsa_pkg::ALARM_NONE)
                r.alarm_event = fdsa_pkg::EVENT_CLEARED;
            else
                r.alarm_event = fdsa_pkg::EVENT_NONE;
            fans[f].last_alarm = kind;
            r.alarm_kind = kind;
            return r;
        endfunction

        function void note_tick(input fdsa_pkg::fan_item_t t);
            expected_results.push_back(predict_fan_result(t));
        endfunction

        task compare_field(input string name, input int got, input int want);
            if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
        endtask

        task check_result(input fdsa_pkg::fan_result_t got);
            fdsa_pkg::fan_result_t want;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing outstanding", got));
            end else begin
                want = expected_results.pop_front();
                compare_field("out_fan", got.out_fan, want.out_fan);
                compare_field("duty_write", got.duty_write, want.duty_write);
                compare_field("duty_value", got.duty_value, want.duty_value);
                compare_field("alarm_event", got.alarm_event, want.alarm_event);
                compare_field("alarm_kind", got.alarm_kind, want.alarm_kind);
                compare_field("source_bad_event", got.source_bad_event, want.source_bad_event);
            end
        endtask
    endclass

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [fdsa_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [fdsa_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [fdsa_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [fdsa_pkg::CFG_DAT_W-1:0]  cfg_data  = '0;
    logic                            steady    = 1'b0;
    int                              idle_cycles = 0;
    fan_result_board                 sb = new();

    fan_duty_slew_and_alarm dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 38);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(fdsa_pkg::fan_result_t'(m_tdata));
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] timeout: no request moved for %0d cycles", $time, idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic fdsa_pkg::fan_item_t make_tick(input int fan, input bit en,
                                                      input bit auto_on,
                                                      input int mduty, input int rpm,
                                                      input logic [fdsa_pkg::SRC_W-1:0] src,
                                                      input int temp,
                                                      input bit curve, input int target);
        fdsa_pkg::fan_item_t t;
        t.fan_id        = fdsa_pkg::FAN_W'(fan);
        t.fan_enabled   = en;
        t.auto_mode     = auto_on;
        t.measured_duty = fdsa_pkg::DUTY_W'(mduty);
        t.measured_rpm  = fdsa_pkg::RPM_W'(rpm);
        t.source_state  = src;
        t.temperature   = fdsa_pkg::TEMP_W'(temp);
        t.curve_found   = curve;
        t.curve_duty    = fdsa_pkg::DUTY_W'(target);
        return t;
    endfunction

    // stalling ticks keep a nonzero duty with the tacho at zero
    function automatic fdsa_pkg::fan_item_t random_tick(input int fan, input bit stalling,
                                                        input int lim);
        fdsa_pkg::fan_item_t t;
        int                  pick, off;
        t.fan_id      = fdsa_pkg::FAN_W'(fan);
        t.fan_enabled = ($urandom_range(0, 9) != 0);
        t.auto_mode   = ($urandom_range(0, 4) != 0);
        if (stalling) begin
            t.measured_duty = fdsa_pkg::DUTY_W'($urandom_range(1, 127));
            t.measured_rpm  = '0;
        end else begin
            t.measured_duty = ($urandom_range(0, 5) == 0) ? '0
                                                          : fdsa_pkg::DUTY_W'($urandom_range(0, 127));
            t.measured_rpm  = ($urandom_range(0, 2) == 0) ? '0 : fdsa_pkg::RPM_W'($urandom);
        end
        pick = $urandom_range(0, 9);
        t.source_state = (pick < 6) ? fdsa_pkg::SRC_VALID :
                         (pick < 8) ? fdsa_pkg::SRC_USABLE :
                         (pick == 8) ? fdsa_pkg::SRC_INVALID : SRC_RESERVED;
        off = $urandom_range(0, 48);
        t.temperature = ($urandom_range(0, 1) == 0) ? fdsa_pkg::TEMP_W'(lim * 16 + off - 24)
                                                    : fdsa_pkg::TEMP_W'($urandom);
        t.curve_found = ($urandom_range(0, 7) != 0);
        t.curve_duty  = ($urandom_range(0, 9) == 0) ? fdsa_pkg::DUTY_W'($urandom_range(101, 127))
                                                    : fdsa_pkg::DUTY_W'($urandom_range(0, 100));
        return t;
    endfunction

    task automatic send_tick(input fdsa_pkg::fan_item_t t);
        while (!steady && $urandom_range(0, 99) < 38) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= fdsa_pkg::S_TDATA_W'(t);
        do @(posedge aclk); while (!s_tready);
        sb.note_tick(t);
    endtask

    task automatic cfg_write(input logic [fdsa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fdsa_pkg::CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic finish_phase();
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic random_setting();
        int lim;
        lim = int'($urandom_range(0, 165)) - 40;
        cfg_write(fdsa_pkg::REG_HYST, {1'($urandom_range(0, 1)), 7'($urandom_range(0, 100))});
        cfg_write(fdsa_pkg::REG_RAMP_UP, {1'($urandom_range(0, 1)), 7'($urandom_range(0, 100))});
        cfg_write(fdsa_pkg::REG_RAMP_DOWN, {1'($urandom_range(0, 1)), 7'($urandom_range(0, 100))});
        cfg_write(fdsa_pkg::REG_FAILSAFE, 8'($urandom));
        cfg_write(fdsa_pkg::REG_FALLBACK_DUTY,
                  {1'($urandom_range(0, 1)), 7'($urandom_range(0, 100))});
        cfg_write(fdsa_pkg::REG_OT_LIMIT, 8'(lim));
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count);
        fdsa_pkg::fan_item_t t;
        int                  n, fan, len, k, lim;
        n = 0;
        while (n < count) begin
            fan = $urandom_range(0, fdsa_pkg::FAN_COUNT - 1);
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 6) : 1;
            for (k = 0; k < len; k++) begin
                lim = $signed(sb.regs.overtemp_limit);
                t = random_tick(fan, len > 1, lim);
                send_tick(t);
                n++;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: band 3, up 10, down 3, safe duty failsafe at 50, limit 80 degrees
        send_tick(make_tick(0, 0, 1, 127, 0, SRC_RESERVED, -1, 1, 127));
        send_tick(make_tick(1, 1, 1, 40, 1200, fdsa_pkg::SRC_VALID, 400, 1, 127));
        send_tick(make_tick(1, 1, 1, 40, 65535, fdsa_pkg::SRC_VALID, 400, 1, 100));
        send_tick(make_tick(1, 1, 1, 40, 900, fdsa_pkg::SRC_VALID, 400, 1, 23));
        send_tick(make_tick(1, 1, 1, 40, 900, fdsa_pkg::SRC_VALID, 400, 1, 0));
        repeat (4) send_tick(make_tick(2, 1, 1, 60, 0, fdsa_pkg::SRC_VALID, 0, 1, 30));
        send_tick(make_tick(2, 1, 1, 60, 0, fdsa_pkg::SRC_VALID, 1281, 1, 30));
        send_tick(make_tick(2, 0, 0, 0, 0, fdsa_pkg::SRC_VALID, 0, 0, 0));
        send_tick(make_tick(2, 1, 1, 60, 500, fdsa_pkg::SRC_VALID, 1280, 1, 30));
        send_tick(make_tick(3, 1, 1, 0, 0, fdsa_pkg::SRC_USABLE, 32767, 1, 50));
        send_tick(make_tick(3, 1, 1, 0, 0, fdsa_pkg::SRC_VALID, -32768, 1, 50));
        send_tick(make_tick(4, 1, 1, 20, 300, fdsa_pkg::SRC_INVALID, 2000, 1, 90));
        send_tick(make_tick(4, 1, 1, 20, 300, SRC_RESERVED, 2000, 1, 90));
        repeat (3) send_tick(make_tick(5, 1, 0, 127, 0, fdsa_pkg::SRC_VALID, 5000, 1, 100));
        send_tick(make_tick(6, 1, 1, 10, 100, fdsa_pkg::SRC_VALID, 3000, 0, 80));
        send_tick(make_tick(7, 1, 1, 100, 65535, fdsa_pkg::SRC_VALID, 1281, 1, 101));
        send_tick(make_tick(7, 1, 1, 100, 65535, fdsa_pkg::SRC_USABLE, 1281, 1, 101));
        finish_phase();
        run_random(130);
        finish_phase();

        // lowest settings, hold failsafe, out of range ramp write dropped
        cfg_write(fdsa_pkg::REG_HYST, 8'd0);
        cfg_write(fdsa_pkg::REG_RAMP_UP, 8'd0);
        cfg_write(fdsa_pkg::REG_RAMP_UP, 8'd127);
        cfg_write(fdsa_pkg::REG_RAMP_DOWN, 8'd0);
        cfg_write(fdsa_pkg::REG_FAILSAFE, {6'd0, fdsa_pkg::FS_HOLD});
        cfg_write(fdsa_pkg::REG_FALLBACK_DUTY, 8'd0);
        cfg_write(fdsa_pkg::REG_OT_LIMIT, 8'h80);
        cfg_valid <= 1'b0;
        run_random(120);
        finish_phase();

        // highest settings, full speed failsafe, both sides without gaps
        cfg_write(fdsa_pkg::REG_HYST, 8'd100);
        cfg_write(fdsa_pkg::REG_HYST, 8'd101);
        cfg_write(fdsa_pkg::REG_RAMP_UP, 8'd100);
        cfg_write(fdsa_pkg::REG_RAMP_DOWN, 8'd100);
        cfg_write(fdsa_pkg::REG_FAILSAFE, {6'd0, fdsa_pkg::FS_FULL});
        cfg_write(fdsa_pkg::REG_FALLBACK_DUTY, 8'd100);
        cfg_write(fdsa_pkg::REG_OT_LIMIT, 8'h7F);
        cfg_valid <= 1'b0;
        steady <= 1'b1;
        run_random(120);
        finish_phase();
        steady <= 1'b0;

        // alternate failsafe, upper data bits, unused indexes
        cfg_write(fdsa_pkg::REG_HYST, 8'd0);
        cfg_write(fdsa_pkg::REG_RAMP_DOWN, 8'd200);
        cfg_write(fdsa_pkg::REG_FAILSAFE, {6'd0, fdsa_pkg::FS_ALT});
        cfg_write(fdsa_pkg::REG_FALLBACK_DUTY, 8'hB3);
        cfg_write(fdsa_pkg::REG_FALLBACK_DUTY, 8'd115);
        cfg_write(fdsa_pkg::REG_OT_LIMIT, 8'hD8);
        cfg_write(REG_UNUSED_A, 8'hFF);
        cfg_write(REG_UNUSED_B, 8'h00);
        cfg_valid <= 1'b0;
        run_random(120);
        finish_phase();

        cfg_write(fdsa_pkg::REG_HYST, 8'd2);
        cfg_write(fdsa_pkg::REG_RAMP_UP, 8'd25);
        cfg_write(fdsa_pkg::REG_RAMP_DOWN, 8'd15);
        cfg_write(fdsa_pkg::REG_FAILSAFE, {6'b111111, fdsa_pkg::FS_SAFE});
        cfg_write(fdsa_pkg::REG_FALLBACK_DUTY, 8'd33);
        cfg_write(fdsa_pkg::REG_OT_LIMIT, 8'd0);
        cfg_valid <= 1'b0;
        run_random(120);
        finish_phase();

        random_setting();
        run_random(120);
        finish_phase();
        random_setting();
        run_random(120);
        finish_phase();

        repeat (8) @(posedge aclk);
        if (sb.expected_results.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_results.size()));
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/fdsa_pkg.sv
sv/fdsa_cfg.sv
sv/fdsa_tick.sv
sv/fan_duty_slew_and_alarm.sv
sv/fdsa_checker.sv
tb/sv/fan_duty_slew_and_alarm_test.sv
